### hw/rtl/rbf_pkg.sv
package rbf_pkg;

   localparam int IDX_W  = 8;
   localparam int DATA_W = 8;
   localparam int CFG_W  = 9;
   localparam int REQ_W  = 24;
   localparam int RSP_W  = 24;

   typedef enum logic [2:0] {
      OP_WRITE      = 3'd0,
      OP_READ       = 3'd1,
      OP_PEEK_FIRST = 3'd2,
      OP_PEEK_LAST  = 3'd3,
      OP_STEP_PREV  = 3'd4,
      OP_STEP_NEXT  = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_BOUNDARY = 2'd3
   } status_type;

endpackage

### hw/rtl/rbf_ram.sv
module rbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### hw/rtl/ring_buffer_fifo.sv
// Circular FIFO with a command interface.
// req channel: one command word per handshake (write, read, peek first,
//   peek last, step prev, step next). rsp channel: exactly one result word
//   per command, in command order.
// csr channel: writes the active depth (clamped to 1..min(DEPTH,256)); the
//   user must do so only while no command is in flight; the block does not
//   enforce it. Contents and indices are kept. A result passes the slot
//   RAM read, then the output register. One command per cycle while rsp is
//   not held off; indices and flags update at the accepting edge, so the
//   next command sees them at once and the RAM needs no forwarding.
// A write with reserve_only set returns the slot's previous content from
//   the RAM's read-before-write port; a plain write returns its own data.
// Stall: if rsp is held off, the output register keeps its word and one
//   more command may enter the RAM stage; then req_tready drops.
// Reset (synchronous): indices zero, full flag clear, depth back to its
//   maximum, pipeline emptied. The slot RAM is not cleared.
module ring_buffer_fifo
   import rbf_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // opcode[2:0], write_data[10:3], reserve_only[11], position[19:12]
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status[1:0], slot_index[9:2], read_data[17:10], now_full[18], now_empty[19]
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int SLOTS = (DEPTH < 256) ? DEPTH : 256;
   localparam int AW    = $clog2(SLOTS);
   localparam logic [CFG_W-1:0] SLOTS_C = CFG_W'(SLOTS);

   function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] eff);
      logic [CFG_W-1:0] n;
      n = {1'b0, idx} + CFG_W'(1);
      return (n >= eff) ? '0 : n[IDX_W-1:0];
   endfunction

   logic [CFG_W-1:0]  eff_depth_ff;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              full_ff, full_in;

   logic              s1_valid_ff;
   logic              s1_ok_ff;
   logic              s1_own_ff;
   status_type        s1_status_ff;
   logic [IDX_W-1:0]  s1_slot_ff;
   logic [DATA_W-1:0] s1_wdata_ff;
   logic              s1_full_ff;
   logic              s1_empty_ff;

   logic              out_valid_ff;
   logic [RSP_W-1:0]  out_data_ff;

   opcode_type        op;
   logic [DATA_W-1:0] wdata;
   logic              reserve;
   logic [IDX_W-1:0]  pos;
   logic              empty_now;
   logic [IDX_W-1:0]  newest;
   logic [IDX_W-1:0]  last_slot;
   status_type        status;
   logic [IDX_W-1:0]  slot;
   logic              ok;
   logic              do_store;
   logic              accept;
   logic              s1_move;
   logic [DATA_W-1:0] ram_q;
   logic [DATA_W-1:0] s1_data;

   assign op        = opcode_type'(req_tdata[2:0]);
   assign wdata     = req_tdata[10:3];
   assign reserve   = req_tdata[11];
   assign pos       = req_tdata[19:12];
   assign empty_now = !full_ff && (wr_idx_ff == rd_idx_ff);
   assign last_slot = IDX_W'(eff_depth_ff - CFG_W'(1));
   assign newest    = (wr_idx_ff != '0) ? (wr_idx_ff - IDX_W'(1)) : last_slot;

   assign s1_move    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      status    = ST_OK;
      slot      = '0;
      ok        = 1'b0;
      do_store  = 1'b0;
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      full_in   = full_ff;
      case (op)
         OP_WRITE: begin
            if (full_ff) begin
               status = ST_FULL;
            end else begin
               slot      = wr_idx_ff;
               ok        = 1'b1;
               do_store  = !reserve;
               wr_idx_in = adv(wr_idx_ff, eff_depth_ff);
               full_in   = (wr_idx_in == rd_idx_ff);
            end
         end
         OP_READ: begin
            if (empty_now) begin
               status = ST_EMPTY;
            end else begin
               slot      = rd_idx_ff;
               ok        = 1'b1;
               rd_idx_in = adv(rd_idx_ff, eff_depth_ff);
               full_in   = 1'b0;
            end
         end
         OP_PEEK_FIRST: begin
            if (empty_now) begin
               status = ST_EMPTY;
            end else begin
               slot = rd_idx_ff;
               ok   = 1'b1;
            end
         end
         OP_PEEK_LAST: begin
            if (empty_now) begin
               status = ST_EMPTY;
            end else begin
               slot = newest;
               ok   = 1'b1;
            end
         end
         OP_STEP_PREV: begin
            if (!empty_now && pos == rd_idx_ff) begin
               status = ST_BOUNDARY;
            end else begin
               slot = (pos != '0) ? (pos - IDX_W'(1)) : last_slot;
               ok   = 1'b1;
            end
         end
         OP_STEP_NEXT: begin
            if (!empty_now && pos == newest) begin
               status = ST_BOUNDARY;
            end else begin
               slot = adv(pos, eff_depth_ff);
               ok   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   rbf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (accept && do_store),
      .wr_addr (slot[AW-1:0]),
      .wr_data (wdata),
      .rd_en   (accept && ok),
      .rd_addr (slot[AW-1:0]),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_depth_ff <= SLOTS_C;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         full_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_data == '0) begin
               eff_depth_ff <= CFG_W'(1);
            end else if (csr_data > SLOTS_C) begin
               eff_depth_ff <= SLOTS_C;
            end else begin
               eff_depth_ff <= csr_data;
            end
         end
         if (accept) begin
            wr_idx_ff <= wr_idx_in;
            rd_idx_ff <= rd_idx_in;
            full_ff   <= full_in;
         end
         if (req_tready) begin
            s1_valid_ff <= accept;
         end
         if (s1_move) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ok_ff     <= ok;
         s1_own_ff    <= do_store;
         s1_status_ff <= status;
         s1_slot_ff   <= slot;
         s1_wdata_ff  <= wdata;
         s1_full_ff   <= full_in;
         s1_empty_ff  <= !full_in && (wr_idx_in == rd_idx_in);
      end
   end

   always_comb begin
      if (!s1_ok_ff) begin
         s1_data = '0;
      end else if (s1_own_ff) begin
         s1_data = s1_wdata_ff;
      end else begin
         s1_data = ram_q;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_valid_ff) begin
         out_data_ff <= {4'b0000, s1_empty_ff, s1_full_ff, s1_data, s1_slot_ff,
                         s1_status_ff};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

### hw/rtl/rbf_checker.sv
module rbf_checker
   import rbf_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   a_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[18] && rsp_tdata[19]))
      else $error("full and empty together");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_OK |-> rsp_tdata[17:2] == '0)
      else $error("refused word carries slot or data");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == ST_FULL |-> rsp_tdata[18])
      else $error("full refusal without full flag");

endmodule

bind ring_buffer_fifo rbf_checker u_rbf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
